/* sv/fan_duty_wind_synthesizer_defines.svh */
// Assertion macros for the fan duty wind synthesizer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FAN_DUTY_WIND_SYNTHESIZER_DEFINES_SVH
`define FAN_DUTY_WIND_SYNTHESIZER_DEFINES_SVH
`ifndef SYNTH
`define FDWS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("fdws: same-cycle check failed");
`define FDWS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("fdws: next-cycle check failed");
`else
`define FDWS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define FDWS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* sv/fdws_pkg.sv */
// Shared types and constants of the fan duty wind synthesizer.
// Used by the controller, the datapath and the top level; no dependencies.
package fdws_pkg;

    localparam int SINE_DEPTH_DEF = 256;
    localparam int PHASE_BITS_DEF = 24;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SMART   = 2'd1;
    localparam logic [1:0] MODE_NATURAL = 2'd2;

    localparam logic [1:0] GUST_IDLE    = 2'd0;
    localparam logic [1:0] GUST_RISING  = 2'd1;
    localparam logic [1:0] GUST_SUSTAIN = 2'd2;
    localparam logic [1:0] GUST_FALLING = 2'd3;

    localparam logic [2:0] REG_LOW_TEMP  = 3'd0;
    localparam logic [2:0] REG_HIGH_TEMP = 3'd1;
    localparam logic [2:0] REG_LOW_DUTY  = 3'd2;
    localparam logic [2:0] REG_HIGH_DUTY = 3'd3;
    localparam logic [2:0] REG_SLEW      = 3'd4;
    localparam logic [2:0] REG_FLOOR     = 3'd5;
    localparam logic [2:0] REG_CEILING   = 3'd6;
    localparam logic [2:0] REG_GUST_ODDS = 3'd7;

    localparam logic signed [15:0] RST_LOW_TEMP  = 16'sd6144;
    localparam logic signed [15:0] RST_HIGH_TEMP = 16'sd8192;
    localparam logic [14:0] RST_LOW_DUTY  = 15'd6400;
    localparam logic [14:0] RST_HIGH_DUTY = 15'd21760;
    localparam logic [14:0] RST_SLEW      = 15'd307;
    localparam logic [14:0] RST_FLOOR     = 15'd3840;
    localparam logic [14:0] RST_CEILING   = 15'd25600;
    localparam logic [15:0] RST_GUST_ODDS = 16'd400;

    localparam logic [31:0] LCG_MUL       = 32'd1664525;
    localparam logic [31:0] LCG_ADD       = 32'd1013904223;
    localparam logic [31:0] SEED_AT_RESET = 32'd123456789;
    localparam logic [31:0] SLOW_INC_Q32  = 32'd1025348;
    localparam logic [31:0] FAST_INC_Q32  = 32'd3417826;

    // Quarter-wave sine polynomial coefficients, Q14.
    localparam logic [14:0] SIN_C1 = 15'd25736;
    localparam logic [14:0] SIN_C3 = 15'd10583;
    localparam logic [14:0] SIN_C5 = 15'd1306;
    localparam logic [31:0] SIN_C7 = 32'd77;

    localparam logic [31:0] TURB_GAIN  = 32'd22938;
    localparam logic [31:0] TURB_KEEP  = 32'd42598;
    localparam logic [2:0]  TURB_HOLD  = 3'd5;
    localparam logic [12:0] GUST_MIN   = 13'd3840;
    localparam logic [31:0] GUST_SPAN  = 32'd3840;
    localparam logic [5:0]  GUST_RISE    = 6'd15;
    localparam logic [5:0]  GUST_SUSTAIN_LEN = 6'd20;
    localparam logic [5:0]  GUST_FALL    = 6'd40;
    // Reciprocals: x/15 = (x*139811)>>21 for x < 161319, y/5 = (y*52429)>>18.
    localparam logic [31:0] RISE_RECIP = 32'd139811;
    localparam logic [31:0] FALL_RECIP = 32'd52429;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_BASE_SEL, OP_NUM, OP_DIV_STEP, OP_DIV_FIN,
        OP_SIN_SETUP, OP_SQ, OP_P1, OP_P2, OP_P3, OP_SOUT, OP_WEATHER,
        OP_SEED, OP_TURB_A, OP_TURB_B, OP_GUST_TEST, OP_GUST_HEIGHT,
        OP_GUST_STEP, OP_GUST_SCALE, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic slot;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       interp;
        logic       hold_zero;
        logic [1:0] stage;
        logic       fire;
        logic       out_free;
    } t_stat;

endpackage

/* sv/fdws_ctrl.sv */
// Sequencer of the fan duty wind synthesizer: walks one tick through the datapath.
// Depends on fdws_pkg for command and status types and the mode and gust codes.
module fdws_ctrl
    import fdws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SMART, S_DIV, S_DIV_FIN, S_SIN_SETUP, S_SQ, S_P1,
        S_P2, S_P3, S_SOUT, S_WEATHER, S_TSEED, S_TA, S_TB, S_GUST, S_GTEST,
        S_GDEC, S_GHEIGHT, S_GSCALE, S_FINISH
    } t_state;

    t_state     r_state, n_state;
    logic       r_slot;
    logic [4:0] r_step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.mode == MODE_SMART) begin
                    n_state = S_SMART;
                end else if (i_stat.mode == MODE_NATURAL) begin
                    n_state = S_SIN_SETUP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SMART: begin
                if (i_stat.interp) begin
                    o_cmd.op = OP_NUM;
                    n_state  = S_DIV;
                end else begin
                    o_cmd.op = OP_BASE_SEL;
                    n_state  = S_FINISH;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_step == 5'd31) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                o_cmd.op = OP_DIV_FIN;
                n_state  = S_FINISH;
            end
            S_SIN_SETUP: begin
                o_cmd.op = OP_SIN_SETUP;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_P1;
            end
            S_P1: begin
                o_cmd.op = OP_P1;
                n_state  = S_P2;
            end
            S_P2: begin
                o_cmd.op = OP_P2;
                n_state  = S_P3;
            end
            S_P3: begin
                o_cmd.op = OP_P3;
                n_state  = S_SOUT;
            end
            S_SOUT: begin
                o_cmd.op = OP_SOUT;
                n_state  = r_slot ? S_WEATHER : S_SIN_SETUP;
            end
            S_WEATHER: begin
                o_cmd.op = OP_WEATHER;
                n_state  = i_stat.hold_zero ? S_TSEED : S_GUST;
            end
            S_TSEED: begin
                o_cmd.op = OP_SEED;
                n_state  = S_TA;
            end
            S_TA: begin
                o_cmd.op = OP_TURB_A;
                n_state  = S_TB;
            end
            S_TB: begin
                o_cmd.op = OP_TURB_B;
                n_state  = S_GUST;
            end
            S_GUST: begin
                if (i_stat.stage == GUST_IDLE) begin
                    o_cmd.op = OP_SEED;
                    n_state  = S_GTEST;
                end else begin
                    o_cmd.op = OP_GUST_STEP;
                    n_state  = S_GSCALE;
                end
            end
            S_GTEST: begin
                o_cmd.op = OP_GUST_TEST;
                n_state  = S_GDEC;
            end
            S_GDEC: begin
                if (i_stat.fire) begin
                    o_cmd.op = OP_SEED;
                    n_state  = S_GHEIGHT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_GHEIGHT: begin
                o_cmd.op = OP_GUST_HEIGHT;
                n_state  = S_FINISH;
            end
            S_GSCALE: begin
                o_cmd.op = OP_GUST_SCALE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_slot <= 1'b0;
            end else if (r_state == S_SOUT) begin
                r_slot <= 1'b1;
            end
            if (r_state == S_SMART) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + 5'd1;
            end
        end
    end

endmodule

/* sv/fdws_dpath.sv */
// Datapath of the fan duty wind synthesizer: registers, one shared multiplier,
// a serial divider and the slew and clamp logic. Depends on fdws_pkg.
module fdws_dpath
    import fdws_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_run_mode,
    input  logic [14:0] i_user_duty,
    input  logic [15:0] i_ambient,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [14:0] o_duty,
    output logic [1:0]  o_gust_phase,
    input  t_cmd        i_cmd,
    output t_stat       o_stat
);

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int SHIFT     = 32 - PHASE_BITS;
    localparam logic [63:0] HALF_LSB = (64'd1 << SHIFT) >> 1;
    localparam logic [PHASE_BITS-1:0] SLOW_INC =
        PHASE_BITS'((64'(SLOW_INC_Q32) + HALF_LSB) >> SHIFT);
    localparam logic [PHASE_BITS-1:0] FAST_INC =
        PHASE_BITS'((64'(FAST_INC_Q32) + HALF_LSB) >> SHIFT);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));

    function automatic logic signed [18:0] f_clamp(logic signed [18:0] v,
                                                   logic signed [18:0] lo,
                                                   logic signed [18:0] hi);
        logic signed [18:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Configuration and long-lived state.
    logic signed [15:0]    r_low_t, r_high_t;
    logic [14:0]           r_lo_duty, r_hi_duty, r_slew, r_floor, r_ceil;
    logic [15:0]           r_odds;
    logic [14:0]           r_present;
    logic [31:0]           r_seed;
    logic [PHASE_BITS-1:0] r_slow, r_fast;
    logic signed [15:0]    r_level;
    logic [2:0]            r_hold;
    logic [1:0]            r_stage;
    logic [12:0]           r_height;
    logic [5:0]            r_count;
    logic                  r_out_valid;

    // Per-tick working registers.
    logic [1:0]         r_mode;
    logic [14:0]        r_user;
    logic signed [15:0] r_ambient;
    logic [14:0]        r_base;
    logic [14:0]        r_t, r_t2, r_p;
    logic               r_neg;
    logic signed [15:0] r_sin0, r_sin1, r_weather;
    logic signed [31:0] r_acc;
    logic               r_fire;
    logic [1:0]         r_gkind;
    logic [18:0]        r_gprod;
    logic [12:0]        r_gust;
    logic [31:0]        r_quo;
    logic [16:0]        r_rem;
    logic               r_qneg;
    logic [14:0]        r_out_duty;
    logic [1:0]         r_out_phase;

    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;

    // Smart mode helpers.
    logic               w_le, w_ge;
    logic signed [16:0] w_tdiff, w_tspan;
    logic signed [15:0] w_ddiff;
    logic [16:0]        w_den;
    logic [17:0]        w_rem_sh, w_rdiff;
    logic               w_rge;
    logic signed [31:0] w_num;
    logic signed [17:0] w_qs, w_sbase;

    // Sine helpers.
    logic [PHASE_BITS-1:0] w_ph;
    logic [ADDR_BITS-1:0]  w_idx;
    logic [15:0]           w_u;
    logic [14:0]           w_tval, w_s;
    logic signed [15:0]    w_sin;
    logic signed [27:0]    w_wsum;

    // Noise, turbulence and gust helpers.
    logic [23:0]        w_m;
    logic [35:0]        w_m2560;
    logic signed [12:0] w_raw;
    logic signed [31:0] w_tsum;
    logic [5:0]         w_cnt1, w_factor;

    // Output helpers.
    logic [14:0]        w_base;
    logic signed [18:0] w_lo, w_hi, w_nat, w_target, w_diff, w_step, w_lim, w_cur, w_pres;

    assign w_le    = (r_ambient <= r_low_t);
    assign w_ge    = (r_ambient >= r_high_t);
    assign w_tdiff = 17'(r_ambient) - 17'(r_low_t);
    assign w_tspan = 17'(r_high_t) - 17'(r_low_t);
    assign w_ddiff = $signed({1'b0, r_hi_duty}) - $signed({1'b0, r_lo_duty});
    assign w_den   = w_tspan;
    assign w_rem_sh = {r_rem, r_quo[31]};
    assign w_rge    = (w_rem_sh >= {1'b0, w_den});
    assign w_rdiff  = w_rem_sh - {1'b0, w_den};
    assign w_num    = w_prod[31:0];
    assign w_qs     = r_qneg ? -$signed({1'b0, r_quo[16:0]}) : $signed({1'b0, r_quo[16:0]});
    assign w_sbase  = $signed({3'd0, r_lo_duty}) + w_qs;

    assign w_ph   = i_cmd.slot ? (r_fast + QUARTER) : r_slow;
    assign w_idx  = w_ph[PHASE_BITS-1 -: ADDR_BITS];
    assign w_u    = 16'(w_idx) << (16 - ADDR_BITS);
    assign w_tval = w_u[14] ? 15'(15'd16384 - {1'b0, w_u[13:0]}) : {1'b0, w_u[13:0]};
    assign w_s    = w_prod[28:14];
    assign w_sin  = r_neg ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});
    assign w_wsum = (28'(r_sin0) <<< 11) + (28'(r_sin0) <<< 9) + (28'(r_sin1) <<< 10)
                  + 28'sd8192;

    assign w_m     = r_seed[23:0];
    assign w_m2560 = ({12'd0, w_m} << 11) + ({12'd0, w_m} << 9);
    assign w_raw   = $signed({1'b0, w_m2560[35:24]}) - 13'sd1280;
    assign w_tsum  = r_acc + $signed(w_prod[31:0]) + 32'sd32768;
    assign w_cnt1  = r_count + 6'd1;

    always_comb begin
        w_factor = '0;
        case (r_stage)
            GUST_RISING:  w_factor = w_cnt1;
            GUST_FALLING: w_factor = (w_cnt1 < GUST_FALL) ? 6'(GUST_FALL - w_cnt1) : 6'd0;
            default:      w_factor = '0;
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_NUM: begin
                w_ma = 32'(w_tdiff);
                w_mb = 32'(w_ddiff);
            end
            OP_SQ: begin
                w_ma = {17'd0, r_t};
                w_mb = {17'd0, r_t};
            end
            OP_P1: begin
                w_ma = {17'd0, r_t2};
                w_mb = SIN_C7;
            end
            OP_P2, OP_P3: begin
                w_ma = {17'd0, r_t2};
                w_mb = {17'd0, r_p};
            end
            OP_SOUT: begin
                w_ma = {17'd0, r_t};
                w_mb = {17'd0, r_p};
            end
            OP_SEED: begin
                w_ma = r_seed;
                w_mb = LCG_MUL;
            end
            OP_TURB_A: begin
                w_ma = 32'(w_raw);
                w_mb = TURB_GAIN;
            end
            OP_TURB_B: begin
                w_ma = 32'(r_level);
                w_mb = TURB_KEEP;
            end
            OP_GUST_TEST: begin
                w_ma = {8'd0, w_m};
                w_mb = {16'd0, r_odds};
            end
            OP_GUST_HEIGHT: begin
                w_ma = {8'd0, w_m};
                w_mb = GUST_SPAN;
            end
            OP_GUST_STEP: begin
                w_ma = {19'd0, r_height};
                w_mb = {26'd0, w_factor};
            end
            OP_GUST_SCALE: begin
                if (r_gkind == GUST_RISING) begin
                    w_ma = {13'd0, r_gprod};
                    w_mb = RISE_RECIP;
                end else begin
                    w_ma = {16'd0, r_gprod[18:3]};
                    w_mb = FALL_RECIP;
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Target, slew limit and clamp of the new duty.
    assign w_base   = (r_mode == MODE_SMART) ? r_base : r_user;
    assign w_lo     = $signed({4'd0, r_floor});
    assign w_hi     = $signed({4'd0, r_ceil});
    assign w_pres   = $signed({4'd0, r_present});
    assign w_nat    = $signed({4'd0, w_base}) + 19'(r_weather) + 19'(r_level)
                    + $signed({6'd0, r_gust});
    assign w_target = (r_mode == MODE_NATURAL) ? f_clamp(w_nat, w_lo, w_hi)
                                               : $signed({4'd0, w_base});
    assign w_diff   = w_target - w_pres;
    assign w_step   = $signed({4'd0, r_slew});
    assign w_lim    = (w_diff > w_step) ? w_step : ((w_diff < -w_step) ? -w_step : w_diff);
    assign w_cur    = f_clamp(w_pres + w_lim, w_lo, w_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_t     <= RST_LOW_TEMP;
            r_high_t    <= RST_HIGH_TEMP;
            r_lo_duty   <= RST_LOW_DUTY;
            r_hi_duty   <= RST_HIGH_DUTY;
            r_slew      <= RST_SLEW;
            r_floor     <= RST_FLOOR;
            r_ceil      <= RST_CEILING;
            r_odds      <= RST_GUST_ODDS;
            r_present   <= '0;
            r_seed      <= SEED_AT_RESET;
            r_slow      <= '0;
            r_fast      <= '0;
            r_level     <= '0;
            r_hold      <= '0;
            r_stage     <= GUST_IDLE;
            r_height    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_LOW_TEMP:  r_low_t   <= i_cfg_wdata;
                    REG_HIGH_TEMP: r_high_t  <= i_cfg_wdata;
                    REG_LOW_DUTY:  r_lo_duty <= i_cfg_wdata[14:0];
                    REG_HIGH_DUTY: r_hi_duty <= i_cfg_wdata[14:0];
                    REG_SLEW:      r_slew    <= i_cfg_wdata[14:0];
                    REG_FLOOR:     r_floor   <= i_cfg_wdata[14:0];
                    REG_CEILING:   r_ceil    <= i_cfg_wdata[14:0];
                    REG_GUST_ODDS: r_odds    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // A new item may replace the one leaving in the same cycle.
            if (i_cmd.op == OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (i_run_mode == MODE_NATURAL) begin
                        r_slow <= r_slow + SLOW_INC;
                        r_fast <= r_fast + FAST_INC;
                    end
                end
                OP_WEATHER: begin
                    if (r_hold != 3'd0) begin
                        r_hold <= r_hold - 3'd1;
                    end
                end
                OP_SEED: r_seed <= w_prod[31:0] + LCG_ADD;
                OP_TURB_B: begin
                    r_level <= 16'(w_tsum >>> 16);
                    r_hold  <= TURB_HOLD;
                end
                OP_GUST_HEIGHT: begin
                    r_stage  <= GUST_RISING;
                    r_height <= GUST_MIN + 13'(w_prod[35:24]);
                    r_count  <= '0;
                end
                OP_GUST_STEP: begin
                    case (r_stage)
                        GUST_RISING: begin
                            if (w_cnt1 >= GUST_RISE) begin
                                r_stage <= GUST_SUSTAIN;
                                r_count <= '0;
                            end else begin
                                r_count <= w_cnt1;
                            end
                        end
                        GUST_SUSTAIN: begin
                            if (w_cnt1 >= GUST_SUSTAIN_LEN) begin
                                r_stage <= GUST_FALLING;
                                r_count <= '0;
                            end else begin
                                r_count <= w_cnt1;
                            end
                        end
                        default: begin
                            if (w_cnt1 >= GUST_FALL) begin
                                r_stage <= GUST_IDLE;
                                r_count <= '0;
                            end else begin
                                r_count <= w_cnt1;
                            end
                        end
                    endcase
                end
                OP_FINISH: begin
                    r_present <= w_cur[14:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode    <= i_run_mode;
                r_user    <= i_user_duty;
                r_ambient <= i_ambient;
                r_gust    <= '0;
            end
            OP_BASE_SEL: r_base <= w_le ? r_lo_duty : r_hi_duty;
            OP_NUM: begin
                r_qneg <= w_num[31];
                r_quo  <= w_num[31] ? 32'(-w_num) : w_num;
                r_rem  <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= w_rge ? w_rdiff[16:0] : w_rem_sh[16:0];
                r_quo <= {r_quo[30:0], w_rge};
            end
            OP_DIV_FIN: r_base <= w_sbase[14:0];
            OP_SIN_SETUP: begin
                r_t   <= w_tval;
                r_neg <= w_u[15];
            end
            OP_SQ: r_t2 <= w_prod[28:14];
            OP_P1: r_p  <= SIN_C5 - w_prod[28:14];
            OP_P2: r_p  <= SIN_C3 - w_prod[28:14];
            OP_P3: r_p  <= SIN_C1 - w_prod[28:14];
            OP_SOUT: begin
                if (i_cmd.slot) begin
                    r_sin1 <= w_sin;
                end else begin
                    r_sin0 <= w_sin;
                end
            end
            OP_WEATHER: r_weather <= 16'(w_wsum >>> 14);
            OP_TURB_A: r_acc <= $signed(w_prod[31:0]);
            OP_GUST_TEST: r_fire <= (w_prod[47:24] == 24'd0);
            OP_GUST_STEP: begin
                r_gkind <= r_stage;
                r_gprod <= w_prod[18:0];
                if (r_stage == GUST_SUSTAIN) begin
                    r_gust <= r_height;
                end
            end
            OP_GUST_SCALE: begin
                if (r_gkind == GUST_RISING) begin
                    r_gust <= w_prod[33:21];
                end else if (r_gkind == GUST_FALLING) begin
                    r_gust <= w_prod[30:18];
                end
            end
            OP_FINISH: begin
                r_out_duty  <= w_cur[14:0];
                r_out_phase <= r_stage;
            end
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_duty       = r_out_duty;
    assign o_gust_phase = r_out_phase;

    assign o_stat.mode      = r_mode;
    assign o_stat.interp    = !w_le && !w_ge;
    assign o_stat.hold_zero = (r_hold == 3'd0);
    assign o_stat.stage     = r_stage;
    assign o_stat.fire      = r_fire;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

/* sv/fan_duty_wind_synthesizer.sv */
// Top level of the fan duty wind synthesizer: sequencer plus datapath.
// Depends on fdws_pkg, fdws_ctrl, fdws_dpath and the assertion macro header.
//
// Usage: one item on the slave stream is one fan tick; it yields one item on
// the master stream with the new PWM duty (Q7.8 percent) and the gust stage.
// Configuration registers are to be written through i_cfg_we/i_cfg_addr/i_cfg_wdata
// only while no tick is in flight; the block itself does not enforce this.
// On the way to the result, normal mode goes straight to the finish; smart mode
// picks a base, or runs a 32-step serial divider when the temperature lies
// between the limits; natural mode works out two sine points, the weather, the
// turbulence when its hold runs out and the gust. The input is ready again in
// the same cycle as the result appears; one tick is worked on at a time, the
// single shared multiplier pacing natural mode and the divider smart mode.
// The result sits in an output register; the next tick is accepted while it
// waits. If the receiver stalls, the following tick holds in its last cycle
// until the output register frees up.
// Synchronous reset returns configuration and state registers to reset values
// and the noise generator to its seed. SINE_TABLE_DEPTH must be a power of two.
`include "fan_duty_wind_synthesizer_defines.svh"
module fan_duty_wind_synthesizer
    import fdws_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [14:0] user_duty, [30:15] ambient, [31] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] run_mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [14:0] duty, [16:15] gust_phase, [23:17] zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    t_cmd        s_cmd;
    t_stat       s_stat;
    logic [14:0] s_duty;
    logic [1:0]  s_phase;
    logic        s_in_acc;

    fdws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    fdws_dpath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_mode   (i_s_axis_tuser),
        .i_user_duty  (i_s_axis_tdata[14:0]),
        .i_ambient    (i_s_axis_tdata[30:15]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_duty       (s_duty),
        .o_gust_phase (s_phase),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat)
    );

    assign o_m_axis_tdata = {7'd0, s_phase, s_duty};
    assign s_in_acc       = i_s_axis_tvalid && o_s_axis_tready;

    `FDWS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_in_acc, !o_s_axis_tready)
    `FDWS_ASSERT_SAME(a_load_on_accept, i_clk, i_rst_n, s_in_acc, s_cmd.op == OP_LOAD)
    `FDWS_ASSERT_NEXT(a_finish_shows_item, i_clk, i_rst_n, s_cmd.op == OP_FINISH, o_m_axis_tvalid)

endmodule

/* tb/fan_duty_wind_synthesizer_test.sv */
// Self-checking testbench of the fan duty wind synthesizer: directed ticks, then random ticks
// under several register settings, checked against a behavioral duty predictor.
// Depends on fdws_pkg and the fan_duty_wind_synthesizer top level.
module fan_duty_wind_synthesizer_test;
    import fdws_pkg::*;

    typedef struct {
        logic [14:0] duty;
        logic [1:0]  gust;
    } t_fan_result;

    typedef struct {
        logic [1:0]  mode;
        int          user;
        int          amb;
        bit          known;
        int          duty;
        logic [1:0]  gust;
    } t_tick_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    fan_duty_wind_synthesizer dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow registers and state of the predicted fan.
    int lo_temp, hi_temp, lo_duty, hi_duty, slew, floor_d, ceil_d, odds;
    int pres, turb, hold, height, cnt;
    logic [31:0] seed;
    logic [23:0] slow_ph, fast_ph;
    logic [1:0]  stage;
    int sine_rom[256];

    t_fan_result duty_queue[$];
    int  errors = 0;
    bit  quiet = 0;

    function automatic longint quarter_sine(longint t);
        longint t2, p;
        t2 = (t * t) >> 14;
        p = 1306 - ((t2 * 77) >> 14);
        p = 10583 - ((t2 * p) >> 14);
        p = 25736 - ((t2 * p) >> 14);
        return (t * p) >> 14;
    endfunction

    function automatic int fan_clamp(int v);
        if (v < floor_d) return floor_d;
        if (v > ceil_d) return ceil_d;
        return v;
    endfunction

    function automatic longint draw_noise();
        seed = seed * LCG_MUL + LCG_ADD;
        return longint'(seed[23:0]);
    endfunction

    function automatic int wind_extra();
        logic [23:0] cos_ph;
        longint raw, v;
        int gust;
        gust = 0;
        slow_ph = slow_ph + 24'((SLOW_INC_Q32 + 128) >> 8);
        fast_ph = fast_ph + 24'((FAST_INC_Q32 + 128) >> 8);
        cos_ph = fast_ph + 24'h400000;
        v = 2560 * longint'(sine_rom[slow_ph[23:16]])
          + 1024 * longint'(sine_rom[cos_ph[23:16]]);
        v = (v + 8192) >>> 14;
        if (hold == 0) begin
            raw = ((draw_noise() * 2560) >> 24) - 1280;
            turb = int'((22938 * raw + 42598 * longint'(turb) + 32768) >>> 16);
            hold = 5;
        end else begin
            hold = hold - 1;
        end
        case (stage)
            GUST_IDLE: begin
                if (((draw_noise() * longint'(odds)) >> 24) == 0) begin
                    stage = GUST_RISING;
                    height = 3840 + int'((draw_noise() * 3840) >> 24);
                    cnt = 0;
                end
            end
            GUST_RISING: begin
                cnt++;
                gust = height * cnt / 15;
                if (cnt >= 15) begin stage = GUST_SUSTAIN; cnt = 0; end
            end
            GUST_SUSTAIN: begin
                cnt++;
                gust = height;
                if (cnt >= 20) begin stage = GUST_FALLING; cnt = 0; end
            end
            default: begin
                cnt++;
                if (cnt < 40) gust = height * (40 - cnt) / 40;
                if (cnt >= 40) begin stage = GUST_IDLE; cnt = 0; end
            end
        endcase
        return int'(v) + turb + gust;
    endfunction

    function automatic t_fan_result advance_fan(logic [1:0] mode, int user, int amb);
        int base, target, diff;
        t_fan_result r;
        base = user;
        if (mode == MODE_SMART) begin
            if (amb <= lo_temp) base = lo_duty;
            else if (amb >= hi_temp) base = hi_duty;
            else base = lo_duty + int'(longint'(amb - lo_temp) * longint'(hi_duty - lo_duty)
                                       / longint'(hi_temp - lo_temp));
        end
        target = (mode == MODE_NATURAL) ? fan_clamp(base + wind_extra()) : base;
        diff = target - pres;
        if (diff > slew) diff = slew;
        if (diff < -slew) diff = -slew;
        pres = fan_clamp(pres + diff) & 32'h7FFF;
        r.duty = pres[14:0];
        r.gust = stage;
        return r;
    endfunction

    task automatic write_regs(input int v[8]);
        for (int i = 0; i < 8; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= i[2:0];
            i_cfg_wdata <= v[i][15:0];
            case (i[2:0])
                REG_LOW_TEMP:  lo_temp = int'($signed(v[i][15:0]));
                REG_HIGH_TEMP: hi_temp = int'($signed(v[i][15:0]));
                REG_LOW_DUTY:  lo_duty = v[i] & 32'h7FFF;
                REG_HIGH_DUTY: hi_duty = v[i] & 32'h7FFF;
                REG_SLEW:      slew = v[i] & 32'h7FFF;
                REG_FLOOR:     floor_d = v[i] & 32'h7FFF;
                REG_CEILING:   ceil_d = v[i] & 32'h7FFF;
                REG_GUST_ODDS: odds = v[i] & 32'hFFFF;
            endcase
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_tick(t_tick_row row);
        int gap;
        t_fan_result r;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= row.mode;
        i_s_axis_tdata <= {1'b0, row.amb[15:0], row.user[14:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = advance_fan(row.mode, row.user, row.amb);
        if (row.known) begin
            r.duty = row.duty[14:0];
            r.gust = row.gust;
        end
        duty_queue.push_back(r);
    endtask

    function automatic int rand_temp();
        return int'($urandom_range(0, 43007)) - 10240;
    endfunction

    // Receiver: a fresh random stall, possibly none, before every item; none while quiet.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_fan_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (duty_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", o_m_axis_tdata);
            end else begin
                e = duty_queue.pop_front();
                if (o_m_axis_tdata[14:0] !== e.duty || o_m_axis_tdata[16:15] !== e.gust
                        || o_m_axis_tdata[23:17] !== '0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected duty %0d gust %0d, got duty %0d gust %0d",
                                 e.duty, e.gust, o_m_axis_tdata[14:0], o_m_axis_tdata[16:15]);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_tick_row rows[$];
        t_tick_row row;
        int v[8];
        int pick;
        for (int i = 0; i < 256; i++) begin
            int u, quad, r;
            u = i * 256;
            quad = (u >> 14) & 3;
            r = u & 16383;
            case (quad)
                0: sine_rom[i] = int'(quarter_sine(r));
                1: sine_rom[i] = int'(quarter_sine(16384 - r));
                2: sine_rom[i] = -int'(quarter_sine(r));
                default: sine_rom[i] = -int'(quarter_sine(16384 - r));
            endcase
        end
        lo_temp = RST_LOW_TEMP; hi_temp = RST_HIGH_TEMP;
        lo_duty = RST_LOW_DUTY; hi_duty = RST_HIGH_DUTY;
        slew = RST_SLEW; floor_d = RST_FLOOR; ceil_d = RST_CEILING; odds = RST_GUST_ODDS;
        pres = 0; turb = 0; hold = 0; height = 0; cnt = 0;
        seed = SEED_AT_RESET; slow_ph = '0; fast_ph = '0; stage = GUST_IDLE;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks; the first ones start from a zero duty under the reset slew.
        rows = '{
            '{MODE_NORMAL, 0, 0, 1, 3840, GUST_IDLE},
            '{MODE_NORMAL, 25600, 0, 1, 4147, GUST_IDLE},
            '{2'd3, 25600, -10240, 1, 4454, GUST_IDLE},
            '{MODE_SMART, 0, -10240, 0, 0, 0},
            '{MODE_SMART, 25600, 32767, 0, 0, 0},
            '{MODE_SMART, 0, 6144, 0, 0, 0},
            '{MODE_SMART, 0, 6145, 0, 0, 0},
            '{MODE_SMART, 0, 7000, 0, 0, 0},
            '{MODE_SMART, 0, 8191, 0, 0, 0},
            '{MODE_SMART, 0, 8192, 0, 0, 0},
            '{MODE_NATURAL, 0, -10240, 0, 0, 0},
            '{MODE_NATURAL, 25600, 32767, 0, 0, 0},
            '{MODE_NATURAL, 12800, -1, 0, 0, 0},
            '{MODE_NATURAL, 21845, 21845, 0, 0, 0},
            '{MODE_NATURAL, 10922, -5462, 0, 0, 0},
            '{MODE_NATURAL, 25600, 0, 0, 0, 0},
            '{MODE_NORMAL, 12345, 0, 0, 0, 0},
            '{2'd3, 0, 32767, 0, 0, 0},
            '{MODE_NORMAL, 25600, -10240, 0, 0, 0}
        };
        foreach (rows[i]) send_tick(rows[i]);

        for (int phase = 0; phase < 6; phase++) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            drain();
            case (phase)
                0: v = '{6144, 8192, 6400, 21760, 307, 3840, 25600, 400};
                1: v = '{-10240, 32767, 0, 25600, 25600, 0, 25600, 1};
                // Crossed limits, a floor above the ceiling, no slew and zero gust odds.
                2: v = '{8192, 6144, 25600, 0, 0, 20000, 5000, 0};
                3: v = '{rand_temp(), 32767, $urandom_range(0, 25600), $urandom_range(0, 25600),
                         1, 0, 25600, 65535};
                default: v = '{rand_temp(), rand_temp(), $urandom_range(0, 25600),
                               $urandom_range(0, 25600), $urandom_range(0, 3000),
                               $urandom_range(0, 8000), $urandom_range(15000, 25600),
                               $urandom_range(1, 60)};
            endcase
            write_regs(v);
            quiet = (phase == 4);
            for (int k = 0; k < 320; k++) begin
                if (k == 100) begin
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                    while (duty_queue.size() != 0) @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                row.mode = (pick < 70) ? MODE_NATURAL : (pick < 85) ? MODE_SMART :
                           (pick < 95) ? MODE_NORMAL : 2'd3;
                row.user = $urandom_range(0, 25600);
                row.amb = rand_temp();
                if (row.mode == MODE_SMART && pick[0] && hi_temp > lo_temp + 1)
                    row.amb = lo_temp + int'($urandom_range(1, hi_temp - lo_temp - 1));
                row.known = 0;
                send_tick(row);
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/fdws_pkg.sv
sv/fdws_ctrl.sv
sv/fdws_dpath.sv
sv/fan_duty_wind_synthesizer.sv
tb/fan_duty_wind_synthesizer_test.sv
